/* rtl/core/dseg_pkg.sv */
`default_nettype none
package dseg_pkg;

    localparam logic [3:0] TOP_ADDRESS   = 4'd8;
    localparam logic [7:0] MINUS_PATTERN = 8'h01;
    // ceil(2^35 / 10): floor(x * RECIP_10 / 2^35) == x / 10 for any 32-bit x
    localparam logic [31:0] RECIP_10     = 32'hCCCC_CCCD;

    typedef struct packed {
        logic signed [31:0] value;
        logic               show_zeros;
        logic [3:0]         field_length;
        logic [2:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [3:0] reg_address;
        logic [7:0] seg_pattern;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_MUL,
        ST_SUB,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sub;
        logic emit_sign;
        logic emit_digit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_len_zero;
        logic in_neg;
        logic dlen_zero;
        logic ext_done;
        logic emit_last;
        logic out_free;
    } t_ctrl_stat;

    // bit layout DP A B C D E F G
    function automatic logic [7:0] seg_lookup(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'b0111_1110;
            4'd1:    p = 8'b0011_0000;
            4'd2:    p = 8'b0110_1101;
            4'd3:    p = 8'b0111_1001;
            4'd4:    p = 8'b0011_0011;
            4'd5:    p = 8'b0101_1011;
            4'd6:    p = 8'b0101_1111;
            4'd7:    p = 8'b0111_0000;
            4'd8:    p = 8'b0111_1111;
            4'd9:    p = 8'b0111_1011;
            default: p = 8'b0000_0000;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/decimal_to_seven_segment_writes_core.sv */
`default_nettype none
// Channel   Signals                      Content
// input     i_valid / o_ready / i_data   value, show_zeros, field_length, position
// output    o_valid / i_ready / o_data   reg_address, seg_pattern, last (one write per item)
// config    psel penable pwrite paddr    digit_count at byte address 0
//
// One item: accepted in ST_IDLE, then the minus sign if negative (ST_SIGN), then each
// digit through the shared divide-by-ten (reciprocal multiply in ST_MUL, then remainder
// in ST_SUB), then each digit written in ST_EMIT, most significant first.
// Writes leave through a single output register; a stalled output holds the sequencer.
// Reset (synchronous, active low) returns digit_count to 8 and empties the output.
// An item whose clamped length is zero is taken in ST_IDLE and gives no write.
module decimal_to_seven_segment_writes_core #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  dseg_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output dseg_pkg::t_out_item  o_data,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [2:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [3:0] r_digit_count;
    logic       reg_hit;

    assign reg_hit = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {28'd0, r_digit_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= 4'd8;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_digit_count <= pwdata[3:0];
        end
    end

    dseg_pkg::t_ctrl_cmd  cmd;
    dseg_pkg::t_ctrl_stat stat;

    dseg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_stat     (stat),
        .o_in_ready (o_ready),
        .o_cmd      (cmd)
    );

    dseg_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_digit_count (r_digit_count),
        .i_item        (i_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .o_out_item    (o_data)
    );

endmodule
`default_nettype wire

/* rtl/core/dseg_ctrl.sv */
`default_nettype none
module dseg_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  dseg_pkg::t_ctrl_stat  i_stat,
    output logic                  o_in_ready,
    output dseg_pkg::t_ctrl_cmd   o_cmd
);

    dseg_pkg::t_state r_state;
    dseg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dseg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dseg_pkg::ST_IDLE: begin
                if (i_in_valid && !i_stat.in_len_zero) begin
                    n_state = i_stat.in_neg ? dseg_pkg::ST_SIGN : dseg_pkg::ST_MUL;
                end
            end
            dseg_pkg::ST_SIGN: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.dlen_zero ? dseg_pkg::ST_IDLE : dseg_pkg::ST_MUL;
                end
            end
            dseg_pkg::ST_MUL: begin
                n_state = dseg_pkg::ST_SUB;
            end
            dseg_pkg::ST_SUB: begin
                n_state = i_stat.ext_done ? dseg_pkg::ST_EMIT : dseg_pkg::ST_MUL;
            end
            dseg_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = dseg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dseg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            dseg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dseg_pkg::ST_SIGN: begin
                o_cmd.emit_sign = i_stat.out_free;
            end
            dseg_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            dseg_pkg::ST_SUB: begin
                o_cmd.sub = 1'b1;
            end
            dseg_pkg::ST_EMIT: begin
                o_cmd.emit_digit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/dseg_datapath.sv */
`default_nettype none
module dseg_datapath #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [3:0]             i_digit_count,
    input  dseg_pkg::t_in_item    i_item,
    input  dseg_pkg::t_ctrl_cmd   i_cmd,
    output dseg_pkg::t_ctrl_stat  o_stat,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output dseg_pkg::t_out_item   o_out_item
);

    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // field clamping on the incoming item
    logic [3:0]  dc_eff;
    logic [3:0]  pos_eff;
    logic [4:0]  span;
    logic [3:0]  len_c;
    logic [3:0]  dlen_c;
    logic        in_neg;
    logic [31:0] in_mag;

    always_comb begin
        if (i_digit_count == 4'd0 || i_digit_count > 4'(MAX_DIGITS)) begin
            dc_eff = 4'(MAX_DIGITS);
        end else begin
            dc_eff = i_digit_count;
        end
        if ({1'b0, i_item.position} >= dc_eff) begin
            pos_eff = dc_eff - 4'd1;
        end else begin
            pos_eff = {1'b0, i_item.position};
        end
        span = {1'b0, pos_eff} + {1'b0, i_item.field_length};
        if (span > {1'b0, dc_eff}) begin
            len_c = dc_eff - pos_eff;
        end else begin
            len_c = i_item.field_length;
        end
        in_neg = i_item.value[31];
        in_mag = in_neg ? (32'd0 - 32'(i_item.value)) : 32'(i_item.value);
        dlen_c = in_neg ? (len_c - 4'd1) : len_c;
    end

    logic [31:0]   r_mag;
    logic [31:0]   r_q;
    logic [3:0]    r_digs [MAX_DIGITS];
    logic [CW-1:0] r_dlen;
    logic [CW-1:0] r_cnt;
    logic [3:0]    r_addr;
    logic          r_show;
    logic          r_out_valid;
    dseg_pkg::t_out_item r_out;

    logic [63:0]   prod;
    logic [31:0]   rem;
    logic [CW-1:0] cnt_dec;
    logic [3:0]    cur_dig;
    logic          blank;
    logic          out_free;

    assign prod    = r_mag * dseg_pkg::RECIP_10;
    // mag - 10*q, with 10*q as 8q + 2q
    assign rem     = r_mag - {r_q[28:0], 3'b000} - {r_q[30:0], 1'b0};
    assign cnt_dec = r_cnt - CW'(1);
    assign cur_dig = r_digs[cnt_dec[IW-1:0]];
    // zeros ahead of the first nonzero digit go dark, never the final one
    assign blank   = !r_show && (cur_dig == 4'd0) && (r_cnt != CW'(1));
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= in_mag;
            r_dlen <= CW'(dlen_c);
            r_cnt  <= '0;
            r_addr <= dseg_pkg::TOP_ADDRESS - pos_eff;
            r_show <= i_item.show_zeros;
        end
        if (i_cmd.mul) begin
            r_q <= {3'b000, prod[63:35]};
        end
        if (i_cmd.sub) begin
            r_digs[r_cnt[IW-1:0]] <= rem[3:0];
            r_mag <= r_q;
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.emit_sign) begin
            r_out.reg_address <= r_addr;
            r_out.seg_pattern <= dseg_pkg::MINUS_PATTERN;
            r_out.last        <= (r_dlen == '0);
            r_addr            <= r_addr - 4'd1;
        end
        if (i_cmd.emit_digit) begin
            r_out.reg_address <= r_addr;
            r_out.seg_pattern <= blank ? 8'h00 : dseg_pkg::seg_lookup(cur_dig);
            r_out.last        <= (r_cnt == CW'(1));
            r_addr            <= r_addr - 4'd1;
            r_cnt             <= cnt_dec;
            if (cur_dig != 4'd0) begin
                r_show <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.in_len_zero = (len_c == 4'd0);
        o_stat.in_neg      = in_neg;
        o_stat.dlen_zero   = (r_dlen == '0);
        o_stat.ext_done    = ({1'b0, r_cnt} + {{CW{1'b0}}, 1'b1}) == {1'b0, r_dlen};
        o_stat.emit_last   = (r_cnt == CW'(1));
        o_stat.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

/* tb/sv/decimal_to_seven_segment_writes_core_test.sv */
`timescale 1ns / 1ps

module decimal_to_seven_segment_writes_core_test;

    localparam int unsigned DISPLAY_DIGITS = 8;
    localparam logic [2:0]  DIGIT_COUNT_ADDR = 3'd0;
    // allow a margin after the last expected write before touching the register
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned STALL_LIMIT = 2000;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    dseg_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_ready;
    dseg_pkg::t_out_item o_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic [3:0]          dc_setting;
    dseg_pkg::t_out_item expected_writes [$];
    int unsigned         error_count;
    int unsigned         stall_left;
    int unsigned         quiet_cycles;
    bit                  no_idle;

    decimal_to_seven_segment_writes_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Expected digit register writes for one number at the current digit count
    function automatic void predict_writes(input dseg_pkg::t_in_item it);
        int unsigned span;
        int unsigned start;
        int unsigned lane;
        int unsigned idx;
        logic [31:0] mag;
        logic [3:0]  digs [DISPLAY_DIGITS];
        logic [3:0]  d;
        logic [3:0]  addr;
        logic [7:0]  glyph;
        bit          lit;
        dseg_pkg::t_out_item w;
        dseg_pkg::t_out_item batch [$];
        span = (dc_setting == 0 || dc_setting > DISPLAY_DIGITS) ? DISPLAY_DIGITS
                                                                : dc_setting;
        start = (it.position >= span) ? span - 1 : it.position;
        lane = it.field_length;
        if (start + lane > span)
            lane = span - start;
        if (lane == 0)
            return;
        addr = dseg_pkg::TOP_ADDRESS - 4'(start);
        mag = it.value;
        if (it.value[31]) begin
            mag = 32'd0 - it.value;
            w.reg_address = addr;
            w.seg_pattern = dseg_pkg::MINUS_PATTERN;
            w.last = 1'b0;
            batch.push_back(w);
            addr = addr - 4'd1;
            lane = lane - 1;
        end
        for (idx = 0; idx < lane; idx++) begin
            digs[idx] = 4'(mag % 10);
            mag = mag / 10;
        end
        lit = it.show_zeros;
        for (idx = 0; idx < lane; idx++) begin
            d = digs[lane - 1 - idx];
            // blank zeros ahead of the first nonzero digit, never the final one
            if (!lit && d == 0 && idx != lane - 1) begin
                glyph = 8'h00;
            end else begin
                if (d != 0)
                    lit = 1'b1;
                glyph = DIGIT_GLYPH[d];
            end
            w.reg_address = addr - 4'(idx);
            w.seg_pattern = glyph;
            w.last = 1'b0;
            batch.push_back(w);
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[n])
            expected_writes.push_back(batch[n]);
    endfunction

    function automatic dseg_pkg::t_in_item make_number(input logic [31:0] v, input bit lz,
                                                       input int unsigned len,
                                                       input int unsigned pos);
        dseg_pkg::t_in_item it;
        it.value = v;
        it.show_zeros = lz;
        it.field_length = 4'(len);
        it.position = 3'(pos);
        return it;
    endfunction

    function automatic logic [31:0] draw_value();
        logic [31:0] v;
        case ($urandom_range(6))
            0: v = $urandom_range(9);
            1: v = $urandom_range(99999);
            2: v = 32'd0 - $urandom_range(999);
            3: v = $urandom_range(99999999);
            4: v = 32'd0 - $urandom_range(9999999);
            5: begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'd0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic dseg_pkg::t_in_item draw_number();
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
        return make_number(draw_value(), $urandom_range(1), len, $urandom_range(7));
    endfunction

    // Caller sits on a rising edge; valid is only dropped when a gap is taken
    task automatic send_number(input dseg_pkg::t_in_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (!o_ready);
        predict_writes(it);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_digit_count(input logic [3:0] count);
        logic [31:0] word;
        word = $urandom;
        word[3:0] = count;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= DIGIT_COUNT_ADDR;
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dc_setting = word[3:0];
    endtask

    task automatic test_directed_numbers();
        send_number(make_number(32'd0, 1'b0, 8, 0));
        send_number(make_number(32'd0, 1'b1, 8, 0));
        send_number(make_number(32'd7, 1'b1, 8, 0));
        send_number(make_number(32'd12345678, 1'b0, 8, 0));
        send_number(make_number(32'd90817263, 1'b0, 8, 0));
        send_number(make_number(32'd100, 1'b0, 2, 0));
        send_number(make_number(32'd1000, 1'b0, 3, 2));
        send_number(make_number(32'h7FFF_FFFF, 1'b0, 8, 0));
        send_number(make_number(32'h8000_0000, 1'b0, 8, 0));
        send_number(make_number(32'h8000_0000, 1'b1, 15, 0));
        send_number(make_number(32'hFFFF_FFFF, 1'b0, 8, 0));
        send_number(make_number(32'hFFFF_FFFF, 1'b1, 4, 4));
        // negative with a single position: minus sign alone
        send_number(make_number(32'd0 - 32'd5, 1'b0, 1, 3));
        send_number(make_number(32'd0 - 32'd5, 1'b0, 1, 7));
        send_number(make_number(32'd42, 1'b0, 0, 0));
        send_number(make_number(32'd42, 1'b1, 0, 7));
        send_number(make_number(32'd9, 1'b0, 15, 7));
        send_number(make_number(32'd98765, 1'b0, 15, 5));
        send_number(make_number(32'd9, 1'b0, 1, 0));
        send_number(make_number(32'd10, 1'b0, 5, 1));
        send_number(make_number(32'd0 - 32'd10, 1'b1, 6, 2));
        send_number(make_number(32'd2468, 1'b1, 9, 6));
        settle();
    endtask

    task automatic test_digit_count_settings();
        logic [3:0] counts [7] = '{4'd1, 4'd8, 4'd0, 4'd9, 4'd15, 4'd4, 4'd7};
        foreach (counts[c]) begin
            write_digit_count(counts[c]);
            no_idle = (c % 3 == 2);
            send_number(make_number(32'h8000_0000, 1'b1, 15, 7));
            send_number(make_number(32'd99999999, 1'b0, 8, 0));
            send_number(make_number(32'd0 - 32'd7, 1'b0, 2, 3));
            repeat (13) send_number(draw_number());
            settle();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_numbers();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0)
                write_digit_count(4'd8);
            else if (phase == 3)
                write_digit_count(4'($urandom_range(15)));
            else
                write_digit_count(4'($urandom_range(8, 1)));
            no_idle = (phase % 3 == 1);
            repeat (50) send_number(draw_number());
            settle();
        end
        no_idle = 1'b0;
    endtask

    // Result side: random back-pressure and in-order comparison
    always @(posedge i_clk) begin : collect_writes
        dseg_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_writes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected write addr %0d pattern %02h last %0b", $time,
                         o_data.reg_address, o_data.seg_pattern, o_data.last);
            end else begin
                want = expected_writes.pop_front();
                if (o_data.reg_address !== want.reg_address) begin
                    error_count++;
                    $display("%0t: reg_address expected %0d actual %0d", $time,
                             want.reg_address, o_data.reg_address);
                end
                if (o_data.seg_pattern !== want.seg_pattern) begin
                    error_count++;
                    $display("%0t: seg_pattern expected %02h actual %02h", $time,
                             want.seg_pattern, o_data.seg_pattern);
                end
                if (o_data.last !== want.last) begin
                    error_count++;
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, o_data.last);
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(9);
            i_ready <= (stall_left == 0);
        end else if (!i_ready) begin
            if (stall_left > 0)
                stall_left--;
            i_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        dc_setting = 4'd8;
        error_count = 0;
        stall_left = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_numbers();
        test_digit_count_settings();
        test_random_numbers();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/core/dseg_pkg.sv
rtl/core/dseg_ctrl.sv
rtl/core/dseg_datapath.sv
rtl/core/decimal_to_seven_segment_writes_core.sv
tb/sv/decimal_to_seven_segment_writes_core_test.sv
